[src/nfts_pkg.sv]
// types and constants shared by the noise filter timebase search unit
`timescale 1ns / 1ps

package nfts_pkg;

  // field widths
  localparam int unsigned THR_W    = 24;
  localparam int unsigned PRESC_W  = 5;
  localparam int unsigned MULT_W   = 8;
  localparam int unsigned PERIOD_W = 32;
  localparam int unsigned CFG_W    = 32;
  localparam int unsigned QUOT_W   = 32;
  localparam int unsigned PROD_W   = QUOT_W + MULT_W;

  // configuration register index
  typedef enum logic [1:0] {
    REG_PRESCALER_BITS  = 2'd0,
    REG_MULTIPLIER_BITS = 2'd1,
    REG_BITDEPTH        = 2'd2,
    REG_MIN_PERIOD      = 2'd3
  } cfg_idx_t;

  // register reset values
  localparam logic [2:0]  RST_PRESCALER_BITS  = 3'd5;
  localparam logic [3:0]  RST_MULTIPLIER_BITS = 4'd4;
  localparam logic [3:0]  RST_BITDEPTH        = 4'd4;
  localparam logic [31:0] RST_MIN_PERIOD      = 32'd2592;

  // search bounds
  localparam logic [2:0] PRESC_BITS_MAX = 3'd5;
  localparam logic [3:0] MULT_BITS_MAX  = 4'd8;
  localparam logic [3:0] DEPTH_MAX      = 4'd8;
  localparam logic [3:0] DEPTH_MIN      = 4'd2;

  // sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_CMP,
    S_DIV,
    S_PERM,
    S_PERC,
    S_DONE
  } state_t;

  // divider handshake
  typedef struct packed {
    logic                start;
    logic [QUOT_W-1:0]   dividend;
    logic [MULT_W-1:0]   divisor;
  } div_req_t;

endpackage

[src/nfts_if.sv]
// input and output channel interfaces of the timebase search unit
`timescale 1ns / 1ps

interface nfts_in_if;
  logic                        valid;
  logic                        ready;
  logic [nfts_pkg::THR_W-1:0]  threshold_value;

  modport source (output valid, output threshold_value, input ready);
  modport sink   (input valid, input threshold_value, output ready);
endinterface

interface nfts_out_if;
  logic                           valid;
  logic                           ready;
  logic [nfts_pkg::PRESC_W-1:0]   chosen_prescaler;
  logic [nfts_pkg::MULT_W-1:0]    chosen_multiplier;
  logic [nfts_pkg::PERIOD_W-1:0]  period_out;
  logic                           found;
  logic                           bad_threshold;

  modport source (output valid, output chosen_prescaler, output chosen_multiplier,
                  output period_out, output found, output bad_threshold, input ready);
  modport sink   (input valid, input chosen_prescaler, input chosen_multiplier,
                  input period_out, input found, input bad_threshold, output ready);
endinterface

[src/nfts_mul.sv]
// shared 32 x 8 multiplier with registered product
`timescale 1ns / 1ps

module nfts_mul (
  input  logic                          clk,
  input  logic [nfts_pkg::QUOT_W-1:0]   a,
  input  logic [nfts_pkg::MULT_W-1:0]   b,
  output logic [nfts_pkg::PROD_W-1:0]   prod
);

  // product register
  always_ff @(posedge clk) begin
    prod <= nfts_pkg::PROD_W'(a) * nfts_pkg::PROD_W'(b);
  end

endmodule

[src/nfts_div.sv]
// radix-2 restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps

module nfts_div (
  input  logic                          clk,
  input  logic                          rst,
  input  nfts_pkg::div_req_t            req,
  output logic                          done,
  output logic [nfts_pkg::QUOT_W-1:0]   quotient
);

  localparam int unsigned CNT_W = $clog2(nfts_pkg::QUOT_W);

  logic                          busy;
  logic [CNT_W-1:0]              cnt;
  logic [nfts_pkg::MULT_W-1:0]   divisor;
  logic [nfts_pkg::MULT_W-1:0]   rem;
  logic [nfts_pkg::MULT_W:0]     rem_sh;
  logic                          qbit;
  logic [nfts_pkg::MULT_W:0]     rem_sub;

  // one restoring step
  always_comb begin
    rem_sh  = {rem, quotient[nfts_pkg::QUOT_W-1]};
    qbit    = (rem_sh >= {1'b0, divisor});
    rem_sub = rem_sh - {1'b0, divisor};
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(nfts_pkg::QUOT_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // dividend shifts out as quotient shifts in
  always_ff @(posedge clk) begin
    if (req.start) begin
      quotient <= req.dividend;
      divisor  <= req.divisor;
      rem      <= '0;
    end else if (busy) begin
      quotient <= {quotient[nfts_pkg::QUOT_W-2:0], qbit};
      rem      <= qbit ? rem_sub[nfts_pkg::MULT_W-1:0] : rem_sh[nfts_pkg::MULT_W-1:0];
    end
  end

endmodule

[src/noise_filter_timebase_search_unit.sv]
// timebase search unit: sequencer over prescaler and multiplier candidates
//
//   channel   dir   beat contents
//   in_ch     in    threshold_value
//   out_ch    out   chosen_prescaler, chosen_multiplier, period_out, found, bad_threshold
//   cfg_*     in    cfg_we, cfg_index, cfg_data (write only)
//
// scan: the sequencer steps the multiplier for each prescaler from 1 to 2^pb - 1; a
//   candidate that needs the compare passes through S_CMP, one that needs a division
//   runs the divider in S_DIV, registers the period product in S_PERM and checks it in
//   S_PERC; the beat is loaded in done
// a zero threshold, or a prescaler width of zero, goes from idle straight to done
// synchronous reset returns the configuration registers to their defaults and the sequencer to idle
// in_ch is ready only while idle; a finished beat waits in the output register

`timescale 1ns / 1ps

module noise_filter_timebase_search_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [1:0]                    cfg_index,
  input  logic [nfts_pkg::CFG_W-1:0]    cfg_data,
  nfts_in_if.sink                       in_ch,
  nfts_out_if.source                    out_ch
);

  // configuration registers
  logic [2:0]  prescaler_bits;
  logic [3:0]  multiplier_bits;
  logic [3:0]  timestamp_bitdepth;
  logic [31:0] min_period;

  nfts_pkg::state_t state, state_next;

  // search registers
  logic [nfts_pkg::THR_W-1:0]    thr;
  logic [nfts_pkg::PRESC_W-1:0]  p;
  logic [nfts_pkg::MULT_W:0]     m;
  logic [31:0]                   acc;
  logic [7:0]                    cand_t;
  logic                          have;
  logic                          bad;
  logic [nfts_pkg::QUOT_W-1:0]   best_quot;
  logic [nfts_pkg::PRESC_W-1:0]  best_p;
  logic [nfts_pkg::MULT_W-1:0]   best_m;
  logic [31:0]                   best_per;
  logic                          out_valid;

  // derived bounds
  logic [2:0]                    pb;
  logic [3:0]                    mb;
  logic [3:0]                    bd;
  logic [nfts_pkg::PRESC_W-1:0]  p_lim;
  logic [nfts_pkg::MULT_W-1:0]   m_lim;
  logic [7:0]                    lim;
  logic [5:0]                    p_end;
  logic [8:0]                    m_end;
  logic [8:0]                    lim_w;

  // candidate arithmetic
  logic [31:0]                   pow;
  logic [31:0]                   half;
  logic [32:0]                   tsum;
  logic [32:0]                   tw;
  logic [31:0]                   per;

  // shared units
  logic [nfts_pkg::QUOT_W-1:0]   mul_a;
  logic [nfts_pkg::MULT_W-1:0]   mul_b;
  logic [nfts_pkg::PROD_W-1:0]   prod;
  nfts_pkg::div_req_t            div_req;
  logic                          div_done;
  logic [nfts_pkg::QUOT_W-1:0]   div_quot;

  // sequencer controls
  logic in_fire;
  logic div_start;
  logic adv_m;
  logic next_p;
  logic take_best;
  logic load_out;

  assign in_fire      = in_ch.valid && in_ch.ready;
  assign in_ch.ready  = (state == nfts_pkg::S_IDLE);
  assign out_ch.valid = out_valid;

  // clamp configuration into search bounds
  always_comb begin
    pb    = (prescaler_bits > nfts_pkg::PRESC_BITS_MAX) ? nfts_pkg::PRESC_BITS_MAX
                                                        : prescaler_bits;
    mb    = (multiplier_bits > nfts_pkg::MULT_BITS_MAX) ? nfts_pkg::MULT_BITS_MAX
                                                        : multiplier_bits;
    bd    = (timestamp_bitdepth > nfts_pkg::DEPTH_MAX) ? nfts_pkg::DEPTH_MAX
                                                       : timestamp_bitdepth;
    p_end = 6'd1 << pb;
    m_end = 9'd1 << mb;
    lim_w = 9'd1 << bd;
    p_lim = nfts_pkg::PRESC_W'(p_end - 6'd1);
    m_lim = nfts_pkg::MULT_W'(m_end - 9'd1);
    lim   = (bd < nfts_pkg::DEPTH_MIN) ? 8'd0 : 8'(lim_w - 9'd2);
  end

  // low-res threshold of the current candidate, acc holds m * thr
  always_comb begin
    pow  = 32'd1 << p;
    half = pow >> 1;
    tsum = {1'b0, acc} + {1'b0, half};
    tw   = tsum >> p;
  end

  // period with saturation
  assign per = (prod[nfts_pkg::PROD_W-1:32] != '0) ? 32'hFFFF_FFFF : prod[31:0];

  // shared multiplier operands
  always_comb begin
    if (state == nfts_pkg::S_PERM) begin
      mul_a = div_quot - 1'b1;
      mul_b = lim - cand_t;
    end else begin
      mul_a = best_quot;
      mul_b = m[nfts_pkg::MULT_W-1:0];
    end
  end

  nfts_mul u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  assign div_req.start    = div_start;
  assign div_req.dividend = pow;
  assign div_req.divisor  = m[nfts_pkg::MULT_W-1:0];

  nfts_div u_div (
    .clk      (clk),
    .rst      (rst),
    .req      (div_req),
    .done     (div_done),
    .quotient (div_quot)
  );

  // next state and sequencer controls
  always_comb begin
    state_next = state;
    div_start  = 1'b0;
    adv_m      = 1'b0;
    next_p     = 1'b0;
    take_best  = 1'b0;
    load_out   = 1'b0;
    case (state)
      nfts_pkg::S_IDLE: begin
        if (in_fire) begin
          if (in_ch.threshold_value == '0 || p_lim == '0) begin
            state_next = nfts_pkg::S_DONE;
          end else begin
            state_next = nfts_pkg::S_SCAN;
          end
        end
      end
      nfts_pkg::S_SCAN: begin
        if (m > {1'b0, m_lim} || tw >= 33'(lim)) begin
          if (p == p_lim) begin
            state_next = nfts_pkg::S_DONE;
          end else begin
            next_p = 1'b1;
          end
        end else if (tw == '0 || 32'(m) > pow) begin
          adv_m = 1'b1;
        end else if (have) begin
          state_next = nfts_pkg::S_CMP;
        end else begin
          div_start  = 1'b1;
          state_next = nfts_pkg::S_DIV;
        end
      end
      nfts_pkg::S_CMP: begin
        // strictly better when 2^p < best_quot * m
        if (prod > nfts_pkg::PROD_W'(pow)) begin
          div_start  = 1'b1;
          state_next = nfts_pkg::S_DIV;
        end else begin
          adv_m      = 1'b1;
          state_next = nfts_pkg::S_SCAN;
        end
      end
      nfts_pkg::S_DIV: begin
        if (div_done) begin
          state_next = nfts_pkg::S_PERM;
        end
      end
      nfts_pkg::S_PERM: begin
        state_next = nfts_pkg::S_PERC;
      end
      nfts_pkg::S_PERC: begin
        if (per != '0 && per >= min_period) begin
          take_best = 1'b1;
        end
        adv_m      = 1'b1;
        state_next = nfts_pkg::S_SCAN;
      end
      nfts_pkg::S_DONE: begin
        if (!out_valid || out_ch.ready) begin
          load_out   = 1'b1;
          state_next = nfts_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = nfts_pkg::S_IDLE;
      end
    endcase
  end

  // state, configuration and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state              <= nfts_pkg::S_IDLE;
      out_valid          <= 1'b0;
      prescaler_bits     <= nfts_pkg::RST_PRESCALER_BITS;
      multiplier_bits    <= nfts_pkg::RST_MULTIPLIER_BITS;
      timestamp_bitdepth <= nfts_pkg::RST_BITDEPTH;
      min_period         <= nfts_pkg::RST_MIN_PERIOD;
    end else begin
      state <= state_next;
      if (out_valid && out_ch.ready) begin
        out_valid <= 1'b0;
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end
      if (cfg_we) begin
        case (nfts_pkg::cfg_idx_t'(cfg_index))
          nfts_pkg::REG_PRESCALER_BITS:  prescaler_bits     <= cfg_data[2:0];
          nfts_pkg::REG_MULTIPLIER_BITS: multiplier_bits    <= cfg_data[3:0];
          nfts_pkg::REG_BITDEPTH:        timestamp_bitdepth <= cfg_data[3:0];
          nfts_pkg::REG_MIN_PERIOD:      min_period         <= cfg_data;
          default: begin
          end
        endcase
      end
    end
  end

  // search datapath
  always_ff @(posedge clk) begin
    if (in_fire) begin
      thr       <= in_ch.threshold_value;
      p         <= nfts_pkg::PRESC_W'(1);
      m         <= 9'd1;
      acc       <= 32'(in_ch.threshold_value);
      have      <= 1'b0;
      bad       <= (in_ch.threshold_value == '0);
      best_quot <= '0;
      best_p    <= '0;
      best_m    <= '0;
      best_per  <= '0;
    end else begin
      if (state == nfts_pkg::S_SCAN) begin
        cand_t <= tw[7:0];
      end
      if (next_p) begin
        p   <= p + 1'b1;
        m   <= 9'd1;
        acc <= 32'(thr);
      end
      if (adv_m) begin
        m   <= m + 1'b1;
        acc <= acc + 32'(thr);
      end
      if (take_best) begin
        have      <= 1'b1;
        best_quot <= div_quot;
        best_p    <= p;
        best_m    <= m[nfts_pkg::MULT_W-1:0];
        best_per  <= per;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (load_out) begin
      out_ch.chosen_prescaler  <= best_p;
      out_ch.chosen_multiplier <= best_m;
      out_ch.period_out        <= best_per;
      out_ch.found             <= have;
      out_ch.bad_threshold     <= bad;
    end
  end

endmodule
